### hw/rtl/md4_pkg.sv
// md4 shared types, constants and step tables
package md4_pkg;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;
  localparam logic [31:0] K_ROUND2 = 32'h5A827999;
  localparam logic [31:0] K_ROUND3 = 32'h6ED9EBA1;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LAST_STEP = 6'd47;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] LEN_POS = 6'd56;

  function automatic logic [31:0] chain_init(input logic [1:0] i);
    logic [31:0] v;
    unique case (i)
      2'd0: v = INIT_A;
      2'd1: v = INIT_B;
      2'd2: v = INIT_C;
      default: v = INIT_D;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] v;
    unique case (r[5:4])
      2'd0: v = r[3:0];
      2'd1: v = {r[1:0], r[3:2]};
      default: v = {r[0], r[1], r[2], r[3]};
    endcase
    return v;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [3:0] k);
    logic [4:0] v;
    unique case (k)
      4'd0: v = 5'd3;
      4'd1: v = 5'd7;
      4'd2: v = 5'd11;
      4'd3: v = 5'd19;
      4'd4: v = 5'd3;
      4'd5: v = 5'd5;
      4'd6: v = 5'd9;
      4'd7: v = 5'd13;
      4'd8: v = 5'd3;
      4'd9: v = 5'd9;
      4'd10: v = 5'd11;
      4'd11: v = 5'd15;
      default: v = 5'd3;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] swap32(input logic [31:0] x);
    return {x[7:0], x[15:8], x[23:16], x[31:24]};
  endfunction

endpackage

### hw/rtl/md4_message_digest_core.sv
// md4 message digest core: top level
//
//   channel   direction  handshake          payload
//   request   in         push / full        data_byte, has_byte, is_last
//   digest    out        pop / empty        digest_high, digest_low
//
// a request with a byte writes it to the block buffer; the 64th byte adds 48 steps and a fold
// a last request adds a pad state, one or two 48-step compressions, a length state
// before the second one, and an emit state
// front register and queue hold FIFO_DEPTH + 1 requests, then full stalls the input
// the digest register holds one result; the engine waits at emit while it is full
// rst is synchronous and restores the initial chaining words and a zero bit count
module md4_message_digest_core #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        is_last,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] digest_high,
  output logic [63:0] digest_low
);

  md4_pkg::q_stat_t q_stat;
  md4_pkg::cmd_t    enq_cmd;
  md4_pkg::cmd_t    head;
  logic             enq;
  logic             deq;

  md4_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .data_byte (data_byte),
    .has_byte  (has_byte),
    .is_last   (is_last),
    .q_stat    (q_stat),
    .enq       (enq),
    .enq_cmd   (enq_cmd)
  );

  md4_cmd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .enq     (enq),
    .enq_cmd (enq_cmd),
    .deq     (deq),
    .head    (head),
    .q_stat  (q_stat)
  );

  md4_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .deq         (deq),
    .pop         (pop),
    .empty       (empty),
    .digest_high (digest_high),
    .digest_low  (digest_low)
  );

endmodule

### hw/rtl/md4_front.sv
// md4 input stage: takes requests, drops empty ones, feeds the command queue
module md4_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [7:0]         data_byte,
  input  logic               has_byte,
  input  logic               is_last,
  input  md4_pkg::q_stat_t   q_stat,
  output logic               enq,
  output md4_pkg::cmd_t      enq_cmd
);

  md4_pkg::cmd_t held;
  logic          held_valid;
  logic          take;

  assign full    = held_valid && q_stat.full;
  assign take    = push && !full;
  assign enq     = held_valid && !q_stat.full;
  assign enq_cmd = held;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= has_byte || is_last;
    end else if (enq) begin
      held_valid <= 1'b0;
    end
    if (take) begin
      held.data <= data_byte;
      held.has  <= has_byte;
      held.last <= is_last;
    end
  end

endmodule

### hw/rtl/md4_cmd_fifo.sv
// md4 command queue between front and engine, shift-register form
module md4_cmd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             enq,
  input  md4_pkg::cmd_t    enq_cmd,
  input  logic             deq,
  output md4_pkg::cmd_t    head,
  output md4_pkg::q_stat_t q_stat
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  md4_pkg::cmd_t q [DEPTH];
  logic [CW-1:0] cnt;
  logic [CW-1:0] widx;
  logic          do_enq;
  logic          do_deq;

  assign q_stat.full  = (cnt == FULL_CNT);
  assign q_stat.empty = (cnt == '0);
  assign head         = q[0];
  assign do_enq       = enq && !q_stat.full;
  assign do_deq       = deq && !q_stat.empty;
  assign widx         = do_deq ? cnt - 1'b1 : cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + CW'(do_enq) - CW'(do_deq);
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (do_enq && (widx[AW-1:0] == AW'(i))) begin
        q[i] <= enq_cmd;
      end else if (do_deq && (i < DEPTH - 1)) begin
        q[i] <= q[(i + 1) % DEPTH];
      end
    end
  end

endmodule

### hw/rtl/md4_engine.sv
// md4 back end: block buffer, 48-step compression, padding and digest register
module md4_engine (
  input  logic             clk,
  input  logic             rst,
  input  md4_pkg::cmd_t    head,
  input  md4_pkg::q_stat_t q_stat,
  output logic             deq,
  input  logic             pop,
  output logic             empty,
  output logic [63:0]      digest_high,
  output logic [63:0]      digest_low
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_ROUND,
    S_FOLD,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    AFTER_IDLE,
    AFTER_PAD,
    AFTER_LEN,
    AFTER_EMIT
  } after_t;

  state_t      state;
  after_t      after;
  logic [31:0] chain [4];
  logic [31:0] blk [16];
  logic [63:0] bit_count;
  logic [31:0] wa, wb, wc, wd;
  logic [5:0]  round;
  logic        out_valid;

  logic [5:0]  pos;
  logic [3:0]  pos_word;
  logic [1:0]  pos_lane;
  logic [31:0] keep_mask;
  logic [31:0] pad_word;
  logic [31:0] f_val;
  logic [31:0] sum;
  logic [4:0]  rot;
  logic [63:0] rot_wide;
  logic [31:0] b_new;

  assign empty    = !out_valid;
  assign deq      = (state == S_IDLE) && !q_stat.empty;
  assign pos      = bit_count[8:3];
  assign pos_word = pos[5:2];
  assign pos_lane = pos[1:0];

  always_comb begin
    unique case (pos_lane)
      2'd0: keep_mask = 32'h0000_0000;
      2'd1: keep_mask = 32'h0000_00ff;
      2'd2: keep_mask = 32'h0000_ffff;
      default: keep_mask = 32'h00ff_ffff;
    endcase
    pad_word = (blk[pos_word] & keep_mask) |
               ({24'd0, md4_pkg::PAD_BYTE} << {pos_lane, 3'b000});
  end

  always_comb begin
    unique case (round[5:4])
      2'd0: f_val = (wb & wc) | (~wb & wd);
      2'd1: f_val = ((wb & wc) | (wb & wd) | (wc & wd)) + md4_pkg::K_ROUND2;
      default: f_val = (wb ^ wc ^ wd) + md4_pkg::K_ROUND3;
    endcase
    sum      = wa + f_val + blk[md4_pkg::msg_index(round)];
    rot      = md4_pkg::rot_amt({round[5:4], round[1:0]});
    rot_wide = {sum, sum} << rot;
    b_new    = rot_wide[63:32];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      after     <= AFTER_IDLE;
      bit_count <= '0;
      round     <= '0;
      wa        <= '0;
      wb        <= '0;
      wc        <= '0;
      wd        <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        chain[i] <= md4_pkg::chain_init(2'(i));
      end
    end else begin
      if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_stat.empty) begin
            if (head.has) begin
              blk[pos_word][{pos_lane, 3'b000} +: 8] <= head.data;
              bit_count <= bit_count + 64'd8;
              if (pos == md4_pkg::LAST_POS) begin
                wa    <= chain[0];
                wb    <= chain[1];
                wc    <= chain[2];
                wd    <= chain[3];
                round <= '0;
                state <= S_ROUND;
                after <= head.last ? AFTER_PAD : AFTER_IDLE;
              end else if (head.last) begin
                state <= S_PAD;
              end
            end else begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          for (int i = 0; i < 16; i++) begin
            if (4'(i) == pos_word) begin
              blk[i] <= pad_word;
            end else if ((i == 14) && (pos < md4_pkg::LEN_POS)) begin
              blk[i] <= bit_count[31:0];
            end else if ((i == 15) && (pos < md4_pkg::LEN_POS)) begin
              blk[i] <= bit_count[63:32];
            end else if (4'(i) > pos_word) begin
              blk[i] <= '0;
            end
          end
          if (pos < md4_pkg::LEN_POS) begin
            after   <= AFTER_EMIT;
          end else begin
            after   <= AFTER_LEN;
          end
          wa    <= chain[0];
          wb    <= chain[1];
          wc    <= chain[2];
          wd    <= chain[3];
          round <= '0;
          state <= S_ROUND;
        end
        S_LEN: begin
          for (int i = 0; i < 14; i++) begin
            blk[i] <= '0;
          end
          blk[14] <= bit_count[31:0];
          blk[15] <= bit_count[63:32];
          wa      <= chain[0];
          wb      <= chain[1];
          wc      <= chain[2];
          wd      <= chain[3];
          round   <= '0;
          after   <= AFTER_EMIT;
          state   <= S_ROUND;
        end
        S_ROUND: begin
          wa <= wd;
          wb <= b_new;
          wc <= wb;
          wd <= wc;
          if (round == md4_pkg::LAST_STEP) begin
            round <= '0;
            state <= S_FOLD;
          end else begin
            round <= round + 6'd1;
          end
        end
        S_FOLD: begin
          chain[0] <= chain[0] + wa;
          chain[1] <= chain[1] + wb;
          chain[2] <= chain[2] + wc;
          chain[3] <= chain[3] + wd;
          unique case (after)
            AFTER_IDLE: state <= S_IDLE;
            AFTER_PAD:  state <= S_PAD;
            AFTER_LEN:  state <= S_LEN;
            default:    state <= S_EMIT;
          endcase
        end
        S_EMIT: begin
          if (!out_valid) begin
            digest_high <= {md4_pkg::swap32(chain[0]), md4_pkg::swap32(chain[1])};
            digest_low  <= {md4_pkg::swap32(chain[2]), md4_pkg::swap32(chain[3])};
            out_valid   <= 1'b1;
            bit_count   <= '0;
            for (int i = 0; i < 4; i++) begin
              chain[i] <= md4_pkg::chain_init(2'(i));
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/md4_checker.sv
// md4 port checker and its bind to the top level
module md4_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic [63:0] digest_high,
  input logic [63:0] digest_low
);

  // reset leaves no digest and an open input
  a_rst_empty: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("md4: digest or full flag visible after reset");

  // a digest needs a full compression after reset
  a_no_early: assert property (@(posedge clk) $fell(empty) |-> !$past(rst, 1) && !$past(rst, 2))
    else $error("md4: digest appeared right after reset");

  // single digest register: a taken result is not replaced in the next cycle
  a_single_slot: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop) |=> empty)
    else $error("md4: new digest right after a pop");

  // a waiting digest holds until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty && $stable(digest_high) && $stable(digest_low))
    else $error("md4: waiting digest changed");

endmodule

bind md4_message_digest_core md4_checker u_md4_checker (
  .clk         (clk),
  .rst         (rst),
  .push        (push),
  .full        (full),
  .pop         (pop),
  .empty       (empty),
  .digest_high (digest_high),
  .digest_low  (digest_low)
);
